// ----- rtl/core/blr_pkg.sv -----
package blr_pkg;

  localparam int COORD_W       = 6;
  localparam int ERR_W         = COORD_W + 3;
  localparam int GRID_SIDE_DEF = 64;
  localparam int QUEUE_DEPTH   = 2;

  typedef logic [COORD_W-1:0]      coord_t;
  typedef logic signed [ERR_W-1:0] err_t;

  // one classified segment, ready for the stepper
  typedef struct packed {
    logic   x_major;
    coord_t maj;
    coord_t maj_end;
    coord_t mnr;
    logic   step_neg;
    err_t   err;
    err_t   inc_flat;
    err_t   inc_step;
  } seg_t;

endpackage

// ----- rtl/core/bresenham_line_rasterizer.sv -----
// bresenham line rasterizer
// input channel: a segment (start_x, start_y, end_x, end_y) transfers at a
//   rising edge where start is high and busy is low
// output channel: one tile per cycle on tile_x / tile_y, marked by tile_valid;
//   last_tile is high on the final tile of a segment
// coordinates above GRID_SIDE-1 are saturated, so a segment gives
//   between 1 and GRID_SIDE tiles
// with the stepper idle, a transferred segment is written into the queue and then
//   loaded into the stepper registers, whose outputs carry its first tile
// throughput: a segment of major length n gives n+1 tiles from the stepper,
//   one tile per cycle; the stepper is the only loop and sets the rate
// a small queue sits between classification and stepping, so new segments
//   are taken while one is still being walked; busy is high when it is full
// segments queued behind each other follow with no idle cycle between them
// reset: queue is emptied and the stepper goes idle; no tile is emitted
// the receiver cannot stall: each tile is valid for exactly one cycle
module bresenham_line_rasterizer
  import blr_pkg::*;
#(
  parameter int GRID_SIDE = GRID_SIDE_DEF
) (
  input  logic   clk,
  input  logic   rst,
  input  logic   start,
  output logic   busy,
  input  coord_t start_x,
  input  coord_t start_y,
  input  coord_t end_x,
  input  coord_t end_y,
  output logic   tile_valid,
  output coord_t tile_x,
  output coord_t tile_y,
  output logic   last_tile
);

  seg_t new_seg;   // classified segment from the front end
  seg_t head_seg;  // oldest queued segment
  logic push, pop, full, empty;

  // the block is busy only while the queue has no room
  assign busy = full;
  assign push = start && !busy;

  // clamp, pick major axis, order endpoints, set up error terms
  blr_front #(
    .GRID_SIDE(GRID_SIDE)
  ) u_front (
    .start_x(start_x),
    .start_y(start_y),
    .end_x  (end_x),
    .end_y  (end_y),
    .seg    (new_seg)
  );

  // decouples input transfers from the stepper
  blr_queue u_queue (
    .clk     (clk),
    .rst     (rst),
    .push    (push),
    .push_seg(new_seg),
    .pop     (pop),
    .head    (head_seg),
    .full    (full),
    .empty   (empty)
  );

  // walks the major axis one tile per cycle
  blr_back u_back (
    .clk       (clk),
    .rst       (rst),
    .empty     (empty),
    .head      (head_seg),
    .pop       (pop),
    .tile_valid(tile_valid),
    .tile_x    (tile_x),
    .tile_y    (tile_y),
    .last_tile (last_tile)
  );

endmodule

// ----- rtl/core/blr_front.sv -----
module blr_front
  import blr_pkg::*;
#(
  parameter int GRID_SIDE = GRID_SIDE_DEF
) (
  input  coord_t start_x,
  input  coord_t start_y,
  input  coord_t end_x,
  input  coord_t end_y,
  output seg_t   seg
);

  localparam coord_t MAX_C = COORD_W'(GRID_SIDE - 1);

  coord_t ax, ay, bx, by;
  coord_t adx, ady, dmaj, dmin;
  coord_t maj0, maj1, min0, min1;
  logic   x_major;
  err_t   dmin2, dmaj_e;

  always_comb begin
    ax = (start_x > MAX_C) ? MAX_C : start_x;
    ay = (start_y > MAX_C) ? MAX_C : start_y;
    bx = (end_x > MAX_C) ? MAX_C : end_x;
    by = (end_y > MAX_C) ? MAX_C : end_y;

    adx = (bx >= ax) ? bx - ax : ax - bx;
    ady = (by >= ay) ? by - ay : ay - by;
    x_major = ady < adx;

    // order endpoints so the major coordinate rises
    if (x_major) begin
      if (ax < bx) begin
        maj0 = ax; maj1 = bx; min0 = ay; min1 = by;
      end else begin
        maj0 = bx; maj1 = ax; min0 = by; min1 = ay;
      end
      dmaj = adx;
      dmin = ady;
    end else begin
      if (ay < by) begin
        maj0 = ay; maj1 = by; min0 = ax; min1 = bx;
      end else begin
        maj0 = by; maj1 = ay; min0 = bx; min1 = ax;
      end
      dmaj = ady;
      dmin = adx;
    end

    dmin2  = signed'({2'b00, dmin, 1'b0});
    dmaj_e = signed'({3'b000, dmaj});

    seg.x_major  = x_major;
    seg.maj      = maj0;
    seg.maj_end  = maj1;
    seg.mnr      = min0;
    seg.step_neg = min1 < min0;
    seg.err      = dmin2 - dmaj_e;
    seg.inc_flat = dmin2;
    seg.inc_step = dmin2 - (dmaj_e <<< 1);
  end

endmodule

// ----- rtl/core/blr_queue.sv -----
module blr_queue
  import blr_pkg::*;
(
  input  logic clk,
  input  logic rst,
  input  logic push,
  input  seg_t push_seg,
  input  logic pop,
  output seg_t head,
  output logic full,
  output logic empty
);

  localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

  seg_t             entries [QUEUE_DEPTH];
  logic [PTR_W-1:0] wr_ptr, rd_ptr;
  logic [CNT_W-1:0] count;

  assign full  = count == CNT_W'(QUEUE_DEPTH);
  assign empty = count == '0;
  assign head  = entries[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= push_seg;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

`ifndef NO_ASSERTIONS
  a_no_push_full: assert property (@(posedge clk) disable iff (rst) push |-> !full)
    else $error("push into full queue");
  a_no_pop_empty: assert property (@(posedge clk) disable iff (rst) pop |-> !empty)
    else $error("pop from empty queue");
  a_count_range: assert property (@(posedge clk) disable iff (rst)
    count <= CNT_W'(QUEUE_DEPTH))
    else $error("queue count out of range");
`endif

endmodule

// ----- rtl/core/blr_back.sv -----
module blr_back
  import blr_pkg::*;
(
  input  logic   clk,
  input  logic   rst,
  input  logic   empty,
  input  seg_t   head,
  output logic   pop,
  output logic   tile_valid,
  output coord_t tile_x,
  output coord_t tile_y,
  output logic   last_tile
);

  logic   active;
  logic   x_major;
  coord_t maj, maj_end, mnr;
  logic   step_neg;
  err_t   err, inc_flat, inc_step;
  logic   is_last, err_pos;

  assign is_last = maj == maj_end;
  assign err_pos = !err[ERR_W-1] && (err != '0);

  // load a new segment when idle or right after the final tile
  assign pop = !empty && (!active || is_last);

  assign tile_valid = active;
  assign tile_x     = x_major ? maj : mnr;
  assign tile_y     = x_major ? mnr : maj;
  assign last_tile  = is_last;

  always_ff @(posedge clk) begin
    if (rst) begin
      active <= 1'b0;
    end else if (pop) begin
      active <= 1'b1;
    end else if (is_last) begin
      active <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      x_major  <= head.x_major;
      maj      <= head.maj;
      maj_end  <= head.maj_end;
      mnr      <= head.mnr;
      step_neg <= head.step_neg;
      err      <= head.err;
      inc_flat <= head.inc_flat;
      inc_step <= head.inc_step;
    end else if (active && !is_last) begin
      maj <= maj + 1'b1;
      if (err_pos) begin
        mnr <= step_neg ? mnr - 1'b1 : mnr + 1'b1;
        err <= err + inc_step;
      end else begin
        err <= err + inc_flat;
      end
    end
  end

`ifndef NO_ASSERTIONS
  a_run_continues: assert property (@(posedge clk) disable iff (rst)
    active && !is_last |=> active)
    else $error("segment dropped before its final tile");
  a_major_rises: assert property (@(posedge clk) disable iff (rst)
    active && !is_last |=> maj == $past(maj) + 1'b1)
    else $error("major coordinate did not advance");
  a_idle_loads: assert property (@(posedge clk) disable iff (rst)
    !active && !empty |=> active)
    else $error("queued segment not started");
`endif

endmodule
